>>> sv/ulist_pkg.sv
// Shared constants and codes for the unsorted list table.
package ulist_pkg;

  // Sizing
  localparam int CAPACITY   = 32;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ACT_W      = 3;
  localparam int STAT_W     = 3;
  localparam int REL_W      = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RST_CUR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET_NEXT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MK_EMPTY = 3'd5;
  localparam logic [ACT_W-1:0] ACT_COMPARE  = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_END      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOCUR    = 3'd4;

  // Relation codes
  localparam logic [REL_W-1:0] REL_LESS    = 2'd0;
  localparam logic [REL_W-1:0] REL_EQUAL   = 2'd1;
  localparam logic [REL_W-1:0] REL_GREATER = 2'd2;
  localparam logic [REL_W-1:0] REL_UNKNOWN = 2'd3;

endpackage

>>> sv/unsorted_list_table.sv
// Unsorted list table: bounded list of signed items with one action per item.
//
// Input channel (in_valid / in_stall) carries an action code and an item;
// every accepted item yields exactly one result on the output channel
// (out_valid / out_stall) with status, found flag, item, relation, length
// and full flag. Items are held in a single-port-read, single-port-write
// memory; one comparator walks it under a small sequencer.
// Insert, reset cursor and make empty pass through an execute step and a
// push step; get next and compare add a fetch step when they read an entry;
// search scans from the head, and delete scans and then shifts the entries
// above the match down. The memory read port, one entry per cycle, sets the
// scan and shift time. One item is in work at a time: the next item is
// accepted only once the result has moved to the output register. in_stall
// is high while an item is in work; a finished result waits in the output
// register, so the next item may be accepted and run up to its own result
// while the receiver stalls.
// Reset empties the list and clears the cursor and the output valid flag;
// memory contents are not cleared and are never read before being written.
module unsorted_list_table (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [ulist_pkg::ACT_W-1:0]             in_action,
  input  logic signed [ulist_pkg::ITEM_WIDTH-1:0] in_item_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [ulist_pkg::STAT_W-1:0]            out_status,
  output logic                                    out_found,
  output logic signed [ulist_pkg::ITEM_WIDTH-1:0] out_item_out,
  output logic [ulist_pkg::REL_W-1:0]             out_relation,
  output logic [ulist_pkg::CNT_W-1:0]             out_list_length,
  output logic                                    out_list_full
);
  import ulist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FETCH, S_SCAN, S_SHIFT, S_PUSH
  } state_t;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Item storage
  logic signed [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic signed [ITEM_WIDTH-1:0] rd_data_r;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic signed [ITEM_WIDTH-1:0] wr_data;

  // Control and list state
  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             cursor_r, cursor_nxt;
  logic                         cur_valid_r, cur_valid_nxt;
  logic [CNT_W-1:0]             rem_r, rem_nxt;
  logic [CNT_W-1:0]             sh_r, sh_nxt;
  logic                         pend_r, pend_nxt;
  logic [IDX_W-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic [ACT_W-1:0]             act_r, act_nxt;
  logic signed [ITEM_WIDTH-1:0] item_r, item_nxt;

  // Staged result
  logic [STAT_W-1:0]            res_status_r, res_status_nxt;
  logic                         res_found_r, res_found_nxt;
  logic signed [ITEM_WIDTH-1:0] res_item_r, res_item_nxt;
  logic [REL_W-1:0]             res_rel_r, res_rel_nxt;

  // Output register
  logic                         out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]            out_status_r, out_status_nxt;
  logic                         out_found_r, out_found_nxt;
  logic signed [ITEM_WIDTH-1:0] out_item_r, out_item_nxt;
  logic [REL_W-1:0]             out_rel_r, out_rel_nxt;
  logic [CNT_W-1:0]             out_len_r, out_len_nxt;
  logic                         out_full_r, out_full_nxt;

  // Helpers
  logic [CNT_W-1:0]             count_m1;
  logic [CNT_W-1:0]             rem_m1;
  logic [CNT_W-1:0]             cursor_ext;
  logic                         in_accept;
  logic                         out_free;

  assign count_m1   = count_r - CNT_W'(1);
  assign rem_m1     = rem_r - CNT_W'(1);
  assign cursor_ext = CNT_W'(cursor_r);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_item_out    = out_item_r;
  assign out_relation    = out_rel_r;
  assign out_list_length = out_len_r;
  assign out_list_full   = out_full_r;

  // Sequencer next-state and memory port control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    cur_valid_nxt  = cur_valid_r;
    rem_nxt        = rem_r;
    sh_nxt         = sh_r;
    pend_nxt       = pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    act_nxt        = act_r;
    item_nxt       = item_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_item_nxt   = res_item_r;
    res_rel_nxt    = res_rel_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_item_nxt   = out_item_r;
    out_rel_nxt    = out_rel_r;
    out_len_nxt    = out_len_r;
    out_full_nxt   = out_full_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = item_r;

    // Drop the output item once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          act_nxt        = in_action;
          item_nxt       = in_item_in;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_item_nxt   = '0;
          res_rel_nxt    = REL_UNKNOWN;
          state_nxt      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_PUSH;
        case (act_r)
          ACT_INSERT: begin
            if (count_r >= CAP_CNT) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end
          ACT_DELETE, ACT_SEARCH: begin
            rem_nxt   = count_r;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
          ACT_RST_CUR: begin
            cursor_nxt    = '0;
            cur_valid_nxt = 1'b0;
          end
          ACT_GET_NEXT: begin
            if (!cur_valid_r) begin
              if (count_r == '0) begin
                res_status_nxt = ST_END;
              end else begin
                cursor_nxt    = count_m1[IDX_W-1:0];
                cur_valid_nxt = 1'b1;
                rd_en         = 1'b1;
                rd_addr       = count_m1[IDX_W-1:0];
                state_nxt     = S_FETCH;
              end
            end else if (cursor_r == '0 || cursor_ext >= count_r) begin
              res_status_nxt = ST_END;
              cursor_nxt     = '0;
              cur_valid_nxt  = 1'b0;
            end else begin
              cursor_nxt = cursor_r - IDX_W'(1);
              rd_en      = 1'b1;
              rd_addr    = cursor_r - IDX_W'(1);
              state_nxt  = S_FETCH;
            end
          end
          ACT_MK_EMPTY: begin
            count_nxt     = '0;
            cursor_nxt    = '0;
            cur_valid_nxt = 1'b0;
          end
          ACT_COMPARE: begin
            if (!cur_valid_r || cursor_ext >= count_r) begin
              res_status_nxt = ST_NOCUR;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = cursor_r;
              state_nxt = S_FETCH;
            end
          end
          default: begin
          end
        endcase
      end

      // Use the single entry read for get next or compare
      S_FETCH: begin
        if (act_r == ACT_GET_NEXT) begin
          res_item_nxt = rd_data_r;
        end else if (item_r > rd_data_r) begin
          res_rel_nxt = REL_GREATER;
        end else if (item_r < rd_data_r) begin
          res_rel_nxt = REL_LESS;
        end else begin
          res_rel_nxt = REL_EQUAL;
        end
        state_nxt = S_PUSH;
      end

      // Walk from the head: issue one read and check the previous one each cycle
      S_SCAN: begin
        if (pend_r && rd_data_r == item_r) begin
          res_found_nxt = 1'b1;
          pend_nxt      = 1'b0;
          if (act_r == ACT_SEARCH) begin
            cursor_nxt    = cmp_idx_r;
            cur_valid_nxt = 1'b1;
            state_nxt     = S_PUSH;
          end else begin
            cursor_nxt    = '0;
            cur_valid_nxt = 1'b0;
            sh_nxt        = CNT_W'(cmp_idx_r) + CNT_W'(1);
            state_nxt     = S_SHIFT;
          end
        end else if (rem_r != '0) begin
          rd_en       = 1'b1;
          rd_addr     = rem_m1[IDX_W-1:0];
          cmp_idx_nxt = rem_m1[IDX_W-1:0];
          rem_nxt     = rem_m1;
          pend_nxt    = 1'b1;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          pend_nxt       = 1'b0;
          state_nxt      = S_PUSH;
        end
      end

      // Close the gap: read entry j+1 and write it to entry j in the next cycle
      S_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = cmp_idx_r - IDX_W'(1);
          wr_data = rd_data_r;
        end
        if (sh_r < count_r) begin
          rd_en       = 1'b1;
          rd_addr     = sh_r[IDX_W-1:0];
          cmp_idx_nxt = sh_r[IDX_W-1:0];
          sh_nxt      = sh_r + CNT_W'(1);
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_m1;
            state_nxt = S_PUSH;
          end
        end
      end

      // Hand the result to the output register when it is free
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_item_nxt   = res_item_r;
          out_rel_nxt    = res_rel_r;
          out_len_nxt    = count_r;
          out_full_nxt   = (count_r == CAP_CNT);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Item memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      cur_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      cur_valid_r <= cur_valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    sh_r         <= sh_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    act_r        <= act_nxt;
    item_r       <= item_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_item_r   <= res_item_nxt;
    res_rel_r    <= res_rel_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_item_r   <= out_item_nxt;
    out_rel_r    <= out_rel_nxt;
    out_len_r    <= out_len_nxt;
    out_full_r   <= out_full_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("list length above capacity");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cursor_ext < count_r))
    else $error("valid cursor points past the list");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(wr_addr) <= count_r) && (count_r < CAP_CNT || state_r == S_SHIFT))
    else $error("memory write outside the list");

  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_PUSH)
    else $error("result raised outside the push step");

endmodule

>>> test/unsorted_list_table_test.sv
// Self-checking testbench for the unsorted list table: directed and random actions against a mirror.
module unsorted_list_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ulist_pkg::*;

  localparam int RST_CYCLES   = 6;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int POOL_N       = 16;
  localparam int RAND_ITEMS   = 850;
  localparam int PRINT_CAP    = 40;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  typedef enum int {PH_FREE, PH_TX_IDLE, PH_RX_STALL, PH_BOTH, PH_FLOOD} phase_t;

  typedef struct {
    logic [ACT_W-1:0]             act;
    logic signed [ITEM_WIDTH-1:0] item;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]            status;
    logic                         found;
    logic signed [ITEM_WIDTH-1:0] item_out;
    logic [REL_W-1:0]             relation;
    logic [CNT_W-1:0]             list_length;
    logic                         list_full;
  } list_answer_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   rst_cycles = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      rst_cycles <= rst_cycles + 1;
      if (rst_cycles == RST_CYCLES - 1) rst_n <= 1'b1;
    end
  end

  // Block ports
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ACT_W-1:0]             in_action = '0;
  logic signed [ITEM_WIDTH-1:0] in_item_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [STAT_W-1:0]            out_status;
  logic                         out_found;
  logic signed [ITEM_WIDTH-1:0] out_item_out;
  logic [REL_W-1:0]             out_relation;
  logic [CNT_W-1:0]             out_list_length;
  logic                         out_list_full;

  unsorted_list_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_item_in      (in_item_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_item_out    (out_item_out),
    .out_relation    (out_relation),
    .out_list_length (out_list_length),
    .out_list_full   (out_list_full)
  );

  // Shared testbench state
  list_cmd_t    cmd_q[$];
  list_answer_t answer_q[$];
  phase_t       phase = PH_FREE;
  int           n_pushed = 0;
  int           n_taken = 0;
  int           err_cnt = 0;
  logic signed [ITEM_WIDTH-1:0] item_pool [POOL_N];

  // List mirror
  logic signed [ITEM_WIDTH-1:0] lst_entries [CAPACITY];
  int lst_count = 0;
  int lst_cursor = 0;
  bit lst_cur_valid = 1'b0;

  task automatic report_mismatch(input string msg);
    if (err_cnt < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int tx_idle_pct();
    if (phase == PH_TX_IDLE) return 71;
    if (phase == PH_BOTH) return 17;
    return 0;
  endfunction

  function automatic int rx_stall_pct();
    if (phase == PH_RX_STALL) return 71;
    if (phase == PH_BOTH) return 17;
    return 0;
  endfunction

  // Index of the first match scanning from the head, or -1
  function automatic int head_match(input logic signed [ITEM_WIDTH-1:0] item);
    for (int i = lst_count - 1; i >= 0; i--)
      if (lst_entries[i] == item) return i;
    return -1;
  endfunction

  // Apply one action to the mirror and build the answer it yields
  task automatic run_list_action(input logic [ACT_W-1:0] act,
                                 input logic signed [ITEM_WIDTH-1:0] item,
                                 output list_answer_t a);
    int pos;
    a.status   = ST_OK;
    a.found    = 1'b0;
    a.item_out = '0;
    a.relation = REL_UNKNOWN;
    case (act)
      ACT_INSERT: begin
        if (lst_count >= CAPACITY) begin
          a.status = ST_FULL;
        end else begin
          lst_entries[lst_count] = item;
          lst_count++;
        end
      end
      ACT_DELETE: begin
        pos = head_match(item);
        if (pos >= 0) begin
          for (int j = pos; j + 1 < lst_count; j++) lst_entries[j] = lst_entries[j + 1];
          lst_count--;
          a.found = 1'b1;
          lst_cursor = 0;
          lst_cur_valid = 1'b0;
        end else begin
          a.status = ST_NOTFOUND;
        end
      end
      ACT_SEARCH: begin
        pos = head_match(item);
        if (pos >= 0) begin
          a.found = 1'b1;
          lst_cursor = pos;
          lst_cur_valid = 1'b1;
        end else begin
          a.status = ST_NOTFOUND;
        end
      end
      ACT_RST_CUR: begin
        lst_cursor = 0;
        lst_cur_valid = 1'b0;
      end
      ACT_GET_NEXT: begin
        if (!lst_cur_valid) begin
          if (lst_count == 0) begin
            a.status = ST_END;
          end else begin
            lst_cursor = lst_count - 1;
            lst_cur_valid = 1'b1;
            a.item_out = lst_entries[lst_cursor];
          end
        end else if (lst_cursor == 0 || lst_cursor >= lst_count) begin
          // walked past the oldest item: drop the cursor
          a.status = ST_END;
          lst_cursor = 0;
          lst_cur_valid = 1'b0;
        end else begin
          lst_cursor--;
          a.item_out = lst_entries[lst_cursor];
        end
      end
      ACT_MK_EMPTY: begin
        lst_count = 0;
        lst_cursor = 0;
        lst_cur_valid = 1'b0;
      end
      ACT_COMPARE: begin
        if (!lst_cur_valid || lst_cursor >= lst_count) a.status = ST_NOCUR;
        else if (item > lst_entries[lst_cursor]) a.relation = REL_GREATER;
        else if (item < lst_entries[lst_cursor]) a.relation = REL_LESS;
        else a.relation = REL_EQUAL;
      end
      default: ;
    endcase
    a.list_length = lst_count[CNT_W-1:0];
    a.list_full   = (lst_count == CAPACITY);
  endtask

  // Driver: offer queued items, hold each until accepted
  always @(posedge clk) begin : drive_proc
    list_answer_t ans;
    list_cmd_t    nxt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        run_list_action(in_action, in_item_in, ans);
        answer_q.push_back(ans);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && !roll(tx_idle_pct())) begin
          nxt = cmd_q.pop_front();
          in_valid   <= 1'b1;
          in_action  <= nxt.act;
          in_item_in <= nxt.item;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest answer, drive stall
  int hold_left = 0;
  bit flood_held = 1'b0;

  always @(posedge clk) begin : check_proc
    list_answer_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = answer_q.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("found", 64'(out_found), 64'(want.found));
          check_field("item_out", 64'(out_item_out), 64'(want.item_out));
          check_field("relation", 64'(out_relation), 64'(want.relation));
          check_field("list_length", 64'(out_list_length), 64'(want.list_length));
          check_field("list_full", 64'(out_list_full), 64'(want.list_full));
        end
      end
      // hold off once for a long stretch in the flood phase
      if (phase == PH_FLOOD && !flood_held) begin
        flood_held <= 1'b1;
        hold_left  <= LONG_HOLD;
        out_stall  <= 1'b1;
      end else if (hold_left > 1) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        hold_left <= 0;
        out_stall <= roll(rx_stall_pct());
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus helpers
  task automatic queue_item(input logic [ACT_W-1:0] act,
                            input logic signed [ITEM_WIDTH-1:0] item);
    list_cmd_t c;
    c.act  = act;
    c.item = item;
    cmd_q.push_back(c);
    n_pushed++;
  endtask

  task automatic refresh_pool();
    item_pool[0] = 32'sh7fff_ffff;
    item_pool[1] = 32'sh8000_0000;
    item_pool[2] = '0;
    item_pool[3] = -1;
    for (int i = 4; i < POOL_N; i++)
      item_pool[i] = roll(50) ? $signed(32'($urandom_range(40))) - 20 : $signed($urandom());
  endtask

  function automatic logic signed [ITEM_WIDTH-1:0] pick_item();
    if (roll(85)) return item_pool[$urandom_range(POOL_N - 1)];
    return $urandom();
  endfunction

  // Queue one short random action sequence; n counts the items that act
  task automatic queue_random_seq(output int n);
    int sel;
    int len;
    int k;
    logic [ACT_W-1:0] act;
    sel = $urandom_range(99);
    n = 0;
    if (sel < 28) begin
      // insert burst, sometimes long enough to fill the list
      len = roll(10) ? $urandom_range(36, 33) : $urandom_range(12, 1);
      repeat (len) queue_item(ACT_INSERT, pick_item());
      n = len;
    end else if (sel < 43) begin
      // search, compare against the found item, then walk on
      queue_item(ACT_SEARCH, pick_item());
      len = $urandom_range(4, 1);
      repeat (len) queue_item(ACT_COMPARE, pick_item());
      k = $urandom_range(5);
      repeat (k) queue_item(ACT_GET_NEXT, $urandom());
      n = 1 + len + k;
    end else if (sel < 58) begin
      len = $urandom_range(3, 1);
      repeat (len) queue_item(ACT_DELETE, pick_item());
      n = len;
    end else if (sel < 73) begin
      // walk the list, comparing now and then
      len = $urandom_range(35, 1);
      for (int i = 0; i < len; i++) begin
        if (roll(20)) queue_item(ACT_COMPARE, pick_item());
        else queue_item(ACT_GET_NEXT, $urandom());
      end
      n = len;
    end else if (sel < 77) begin
      queue_item(ACT_MK_EMPTY, $urandom());
      n = 1;
    end else if (sel < 85) begin
      queue_item(ACT_RST_CUR, $urandom());
      k = $urandom_range(3, 1);
      repeat (k) queue_item(ACT_GET_NEXT, $urandom());
      n = 1 + k;
    end else begin
      // noise: any code, any item
      act = ACT_W'($urandom_range(7));
      queue_item(act, $urandom());
      n = (act == ACT_UNUSED) ? 0 : 1;
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_pushed || answer_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed items, then random phases, each run until drained
  initial begin : stim_proc
    phase_t plan [10] = '{PH_FREE, PH_TX_IDLE, PH_RX_STALL, PH_BOTH, PH_FLOOD,
                          PH_TX_IDLE, PH_RX_STALL, PH_BOTH, PH_FREE, PH_BOTH};
    int made;
    int n;
    int target;
    wait (rst_n === 1'b1);

    // directed: empty list, extremes, cursor corner cases
    queue_item(ACT_COMPARE, 32'sd5);
    queue_item(ACT_GET_NEXT, 32'sh5a5a_5a5a);
    queue_item(ACT_DELETE, 32'sd1);
    queue_item(ACT_INSERT, 32'sh7fff_ffff);
    queue_item(ACT_INSERT, 32'sh8000_0000);
    queue_item(ACT_INSERT, 32'sd0);
    queue_item(ACT_INSERT, -32'sd1);
    queue_item(ACT_SEARCH, 32'sd12345);
    queue_item(ACT_SEARCH, 32'sh8000_0000);
    queue_item(ACT_COMPARE, 32'sh7fff_ffff);
    queue_item(ACT_COMPARE, 32'sh8000_0000);
    queue_item(ACT_INSERT, 32'sd5);
    queue_item(ACT_COMPARE, 32'sh8000_0000);
    queue_item(ACT_SEARCH, 32'sh7fff_ffff);
    queue_item(ACT_COMPARE, 32'sd0);
    queue_item(ACT_GET_NEXT, 32'sh0);
    queue_item(ACT_GET_NEXT, -32'sd1);
    queue_item(ACT_GET_NEXT, 32'sh1234_5678);
    queue_item(ACT_DELETE, 32'sd0);
    queue_item(ACT_COMPARE, 32'sd0);
    queue_item(ACT_UNUSED, 32'shffff_ffff);
    queue_item(ACT_RST_CUR, 32'sh5555_5555);
    queue_item(ACT_GET_NEXT, 32'shaaaa_aaaa);
    queue_item(ACT_MK_EMPTY, 32'sh0f0f_0f0f);
    queue_item(ACT_GET_NEXT, 32'shf0f0_f0f0);
    wait_drained();

    // random phases
    made = 0;
    foreach (plan[p]) begin
      refresh_pool();
      target = (plan[p] == PH_FLOOD) ? 60 : (RAND_ITEMS - 60) / 9;
      phase = plan[p];
      n = 0;
      while (n < target) begin
        queue_random_seq(made);
        n += made;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (answer_q.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ulist_pkg.sv
sv/unsorted_list_table.sv
test/unsorted_list_table_test.sv
